@@ sv/afas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afas_pkg - shared types and constants of the audio fade alarm sequencer
// Holds the result bundle, register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
package afas_pkg;

	// Width of the frame count field of one audio block.
	localparam int FRAMES_W = 13;

	// Width of the register index on the configuration port.
	localparam int CFG_INDEX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_FRAMES = 1'd1;

	// Reset values of the registers, before trimming to their widths.
	localparam logic [31:0] FADE_STEP_RESET    = 32'd16;
	localparam logic [31:0] ALARM_FRAMES_RESET = 32'd960000;

	// One result item. The last member lands in bit 0 of the packed value.
	typedef struct packed {
		logic alarm_done;
		logic idle;
		logic falling;
		logic tone;
		logic init_tone;
		logic init_sound;
		logic power_down;
		logic power_up;
	} result_t;

endpackage : afas_pkg
`default_nettype wire

@@ sv/audio_fade_alarm_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fade_alarm_sequencer - fade and alarm control, one step per block
// Input register, combinational control step, result register.
// ----------------------------------------------------------------------------
// The input register loads at the input transfer, and the result register
// takes the control step of that block once the result register is free;
// a stalled result holds the block in the input register.
// Throughput: one audio block per cycle while the result side does not stall;
// the phase, fade and countdown update of one block completes in the cycle it leaves the input register.
// Reset: arst_n clears the pipeline valids, the phase (idle), the fade level,
// the alarm countdown and the resume flag, and loads the register defaults.
module audio_fade_alarm_sequencer #(
	parameter int FADE_FRAC_BITS = 16,
	parameter int COUNT_BITS     = 24
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Configuration write port, no read-back.
	input  wire                                   cfg_we,
	input  wire [afas_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire [((FADE_FRAC_BITS + 1 > COUNT_BITS) ?
		(FADE_FRAC_BITS + 1) : COUNT_BITS)-1:0]   cfg_data,
	// Block requests. tdata from bit 0: want_play, want_alarm, restart,
	// frames[12:0].
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire [15:0]                            s_axis_tdata,
	// Block results. tdata from bit 0: power_up, power_down, init_sound,
	// init_tone, tone, falling, idle, alarm_done.
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	output logic [7:0]                            m_axis_tdata
);
	import afas_pkg::*;

	localparam int SW = FADE_FRAC_BITS + 1;

	// Configuration registers.
	logic [SW-1:0]         fade_step_q;
	logic [COUNT_BITS-1:0] alarm_frames_q;

	// Input register stage.
	logic                  valid_s1;
	logic                  want_play_s1;
	logic                  want_alarm_s1;
	logic                  restart_s1;
	logic [FRAMES_W-1:0]   frames_s1;

	// Result register.
	logic                  out_valid_q;
	result_t               out_res_q;
	result_t               step_res;

	logic                  out_free;
	logic                  fire;

	// The result register can take a new result when it is empty or its
	// current result is being transferred this cycle. A block in the input
	// register is processed (and the state updated) only at that moment, so
	// the state always advances exactly once per delivered result.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q    <= SW'(FADE_STEP_RESET);
			alarm_frames_q <= COUNT_BITS'(ALARM_FRAMES_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FADE_STEP:    fade_step_q    <= cfg_data[SW-1:0];
				REG_ALARM_FRAMES: alarm_frames_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			want_play_s1  <= s_axis_tdata[0];
			want_alarm_s1 <= s_axis_tdata[1];
			restart_s1    <= s_axis_tdata[2];
			frames_s1     <= s_axis_tdata[3 +: FRAMES_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res_q <= step_res;
		end
	end

	// Phase machine, fade ramp and alarm countdown.
	afas_seq #(
		.FADE_FRAC_BITS (FADE_FRAC_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.want_play    (want_play_s1),
		.want_alarm   (want_alarm_s1),
		.restart      (restart_s1),
		.frames       (frames_s1),
		.fade_step    (fade_step_q),
		.alarm_frames (alarm_frames_q),
		.res          (step_res)
	);

endmodule : audio_fade_alarm_sequencer
`default_nettype wire

@@ sv/afas_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afas_seq - phase machine, fade level and alarm countdown
// Computes one control step per audio block and updates the state registers.
// ----------------------------------------------------------------------------
module afas_seq #(
	parameter int FADE_FRAC_BITS = 16,
	parameter int COUNT_BITS     = 24
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             fire,
	input  wire                             want_play,
	input  wire                             want_alarm,
	input  wire                             restart,
	input  wire [afas_pkg::FRAMES_W-1:0]    frames,
	input  wire [FADE_FRAC_BITS:0]          fade_step,
	input  wire [COUNT_BITS-1:0]            alarm_frames,
	output afas_pkg::result_t               res
);
	import afas_pkg::*;

	localparam int LW = FADE_FRAC_BITS + 1;
	localparam int DW = LW + FRAMES_W;
	localparam int PW = COUNT_BITS + LW;
	localparam logic [LW-1:0] FULL_SCALE = LW'(1) << FADE_FRAC_BITS;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_RUN  = 3'd1,
		PH_STOP = 3'd2,
		PH_DUCK = 3'd3,
		PH_RING = 3'd4,
		PH_REL  = 3'd5
	} phase_t;

	phase_t               phase_q, phase_mid, phase_nx;
	logic [LW-1:0]        level_q, level_nx;
	logic [COUNT_BITS-1:0] left_q, left_mid, left_nx;
	logic                 resume_q, resume_nx;
	logic                 early;
	logic                 fall;
	logic [PW-1:0]        ring_prod;
	logic [DW-1:0]        delta;
	logic [DW:0]          rise_sum;
	logic [DW-1:0]        level_ext;
	logic                 level_zero;

	assign level_zero = (level_q == '0);
	assign delta      = DW'(fade_step) * DW'(frames);
	assign level_ext  = DW'(level_q);
	assign rise_sum   = (DW+1)'(level_q) + (DW+1)'(delta);
	assign ring_prod  = PW'(left_mid) * PW'(fade_step);

	always_comb begin
		phase_mid = phase_q;
		left_mid  = left_q;
		resume_nx = resume_q;
		early     = 1'b0;
		res       = '0;

		case (phase_q)
			PH_RUN: begin
				if (want_alarm) begin
					resume_nx = 1'b1;
					phase_mid = PH_DUCK;
				end else if (!want_play) begin
					phase_mid = PH_STOP;
				end else if (restart && level_zero) begin
					res.init_sound = 1'b1;
				end
			end
			PH_STOP: begin
				if (want_alarm) begin
					resume_nx = 1'b0;
					phase_mid = PH_DUCK;
				end else if (want_play) begin
					phase_mid = PH_RUN;
				end
			end
			PH_DUCK: begin
				if (!want_alarm) begin
					phase_mid = PH_REL;
				end else if (level_zero) begin
					res.init_tone = 1'b1;
					left_mid      = alarm_frames;
					phase_mid     = PH_RING;
				end
			end
			PH_RING: begin
				if (!want_alarm) begin
					left_mid = '0;
				end
				if (!want_alarm || left_q == '0) begin
					phase_mid = PH_REL;
				end
			end
			PH_REL: begin
				if (level_zero) begin
					res.alarm_done = 1'b1;
					if (resume_q && want_play) begin
						phase_mid = PH_RUN;
					end else begin
						res.power_down = 1'b1;
						res.idle       = 1'b1;
						phase_mid      = PH_IDLE;
						early          = 1'b1;
					end
				end
			end
			default: begin
				// Idle, and the unused codes behave the same way.
				phase_mid = PH_IDLE;
				if (want_alarm) begin
					res.power_up  = 1'b1;
					res.init_tone = 1'b1;
					left_mid      = alarm_frames;
					resume_nx     = 1'b0;
					phase_mid     = PH_RING;
				end else if (want_play) begin
					res.power_up   = 1'b1;
					res.init_sound = 1'b1;
					phase_mid      = PH_RUN;
				end else begin
					res.idle = 1'b1;
					early    = 1'b1;
				end
			end
		endcase

		phase_nx = phase_mid;
		left_nx  = left_mid;
		level_nx = level_q;
		fall     = 1'b0;

		if (!early) begin
			res.tone = (phase_mid == PH_RING) || (phase_mid == PH_REL);
			if (phase_mid == PH_RING) begin
				fall = (ring_prod <= PW'(FULL_SCALE));
			end else begin
				fall = (phase_mid == PH_STOP) || (phase_mid == PH_DUCK) ||
					(phase_mid == PH_REL);
			end
			res.falling = fall;

			if (fall) begin
				level_nx = (level_ext > delta) ? LW'(level_ext - delta) : '0;
			end else begin
				level_nx = (rise_sum > (DW+1)'(FULL_SCALE)) ? FULL_SCALE
					: LW'(rise_sum);
			end

			if (phase_mid == PH_RING) begin
				left_nx = (left_mid > COUNT_BITS'(frames))
					? left_mid - COUNT_BITS'(frames) : '0;
			end

			if (phase_mid == PH_STOP && level_nx == '0) begin
				res.power_down = 1'b1;
				phase_nx       = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			level_q  <= '0;
			left_q   <= '0;
			resume_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_nx;
			level_q  <= level_nx;
			left_q   <= left_nx;
			resume_q <= resume_nx;
		end
	end

endmodule : afas_seq
`default_nettype wire
